// ----- hdl/crc_framed_register_link_slave_defines.svh -----
// assertion macros used by the checker of the link slave
`ifndef CRC_FRAMED_REGISTER_LINK_SLAVE_DEFINES_SVH
`define CRC_FRAMED_REGISTER_LINK_SLAVE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CRCFL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CRCFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hdl/crcfl_pkg.sv -----
package crcfl_pkg;

	// register store geometry
	localparam int REG_DEPTH = 4096;
	localparam int ADDR_W    = $clog2(REG_DEPTH);
	localparam logic [16:0] DEPTH_L = 17'(REG_DEPTH);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(REG_DEPTH - 1);

	// frame constants
	localparam logic [7:0]  SYNC_FIRST  = 8'hAB;
	localparam logic [7:0]  SYNC_SECOND = 8'hCD;
	localparam logic [15:0] CRC_TOP_BIT = 16'h8000;
	localparam logic [3:0]  STEP_LAST   = 4'd8;  // byte index of the closing crc byte
	localparam logic [2:0]  CHECK_LAST  = 3'd6;  // last byte covered by the crc
	localparam logic [3:0]  CRC_HI_IDX  = 4'd7;
	localparam logic [3:0]  REPLY_LAST  = 4'd8;

	// input modes
	localparam logic [1:0] MODE_RX      = 2'd0;
	localparam logic [1:0] MODE_CLEAR   = 2'd1;
	localparam logic [1:0] MODE_HOST_WR = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_REPLY   = 2'd0;
	localparam logic [1:0] KIND_CRC_ERR = 2'd1;
	localparam logic [1:0] KIND_QUERY   = 2'd2;
	localparam logic [1:0] KIND_ACCEPT  = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEND     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUEST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE = 3'd4;

	// one reply job handed from the frame logic to the transmitter
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  code;
		logic [15:0] addr;
		logic [15:0] data;
		logic        persist;
	} tx_job_t;

	// msb-first crc-16, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
		input logic [15:0] poly);
		logic [15:0] t;
		t = {crc[15:8] ^ b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((t & CRC_TOP_BIT) != 16'h0000) begin
				t = {t[14:0], 1'b0} ^ poly;
			end else begin
				t = {t[14:0], 1'b0};
			end
		end
		return {crc[7:0], 8'h00} ^ t;
	endfunction

endpackage

// ----- hdl/crcfl_tx.sv -----
module crcfl_tx import crcfl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] crc_poly,
	input  logic        job_valid,
	input  tx_job_t     job,
	output logic        busy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [15:0] reg_addr,
	output logic        persist_request
);

	tx_job_t     job_q;
	logic        gen_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [15:0] addr_q;
	logic        persist_q;

	logic       load;
	logic       single;
	logic       is_last;
	logic [7:0] cur_byte;

	assign load    = gen_q && (!out_valid_q || out_ready);
	assign single  = job_q.kind != KIND_REPLY;
	assign is_last = single || (idx_q == REPLY_LAST);

	always_comb begin
		case (idx_q)
			4'd0:    cur_byte = SYNC_FIRST;
			4'd1:    cur_byte = SYNC_SECOND;
			4'd2:    cur_byte = job_q.code;
			4'd3:    cur_byte = job_q.addr[15:8];
			4'd4:    cur_byte = job_q.addr[7:0];
			4'd5:    cur_byte = job_q.data[15:8];
			4'd6:    cur_byte = job_q.data[7:0];
			4'd7:    cur_byte = crc_q[15:8];
			4'd8:    cur_byte = crc_q[7:0];
			default: cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					gen_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (job_valid && !gen_q) begin
				gen_q <= 1'b1;
				idx_q <= 4'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && !gen_q) begin
			job_q <= job;
			crc_q <= 16'h0000;
		end else if (load && (idx_q < CRC_HI_IDX)) begin
			crc_q <= crc_byte(crc_q, cur_byte, crc_poly);
		end
		if (load) begin
			kind_q    <= job_q.kind;
			byte_q    <= single ? 8'h00 : cur_byte;
			last_q    <= is_last;
			addr_q    <= job_q.addr;
			persist_q <= is_last && !single && job_q.persist;
		end
	end

	assign busy            = gen_q;
	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign tx_byte         = byte_q;
	assign last            = last_q;
	assign reg_addr        = addr_q;
	assign persist_request = persist_q;

endmodule

// ----- hdl/crc_framed_register_link_slave.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------------------
// in        | in_valid / in_ready       | mode, rx_byte, host_addr, host_value
// out       | out_valid / out_ready     | kind, tx_byte, last, reg_addr, persist_request
// cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// with tx idle, input takes one received byte, busy clear or host write per cycle
// the closing byte of a frame holds the input through ST_CHECK, the crc check over
// the buffered bytes (one byte a cycle through the crc step), ST_EVAL for the store
// access and ST_JOB to hand the job to the transmitter, which then makes one result
// per cycle unless out_ready stalls it (9 for a reply) while the input waits
// after reset the register store is swept to zero, one entry a cycle, all REG_DEPTH entries
// results sit in an output register, so input flows again while the last one waits to be taken
module crc_framed_register_link_slave import crcfl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input transactions
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          host_addr,
	input  logic [15:0]          host_value,
	// result transactions
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           kind,
	output logic [7:0]           tx_byte,
	output logic                 last,
	output logic [15:0]          reg_addr,
	output logic                 persist_request,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	typedef enum logic [2:0] {
		ST_CLEAR, // zero sweep of the store after reset
		ST_RUN,   // bytes and host commands flow
		ST_CHECK, // crc over buffered frame bytes
		ST_EVAL,  // decide, store write or read
		ST_JOB    // read data back, job to transmitter
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] crc_poly_q;
	logic [7:0]  code_send_q;
	logic [7:0]  code_request_q;
	logic [7:0]  code_query_q;
	logic [7:0]  code_response_q;

	// frame hunt state
	logic [3:0]        step_q;
	logic              busy_q;
	logic [2:0]        chk_idx_q;
	logic [ADDR_W-1:0] clr_idx_q;

	// frame buffer and check crc (payload, no reset)
	logic [7:0]  frame_q [8];
	logic [7:0]  last_byte_q;
	logic [15:0] crc_q;

	// job under construction
	tx_job_t job_q;
	logic    rd_sel_q;
	logic    oob_q;
	tx_job_t tx_job;
	logic    tx_busy;

	// register store
	logic [15:0]       mem [REG_DEPTH];
	logic [15:0]       rd_data_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;

	logic        in_fire;
	logic [7:0]  f_type;
	logic [15:0] f_addr;
	logic [15:0] f_data;
	logic        f_in_range;
	logic        host_in_range;
	logic        crc_ok;
	logic        is_send;
	logic        is_req;
	logic        is_query;

	assign in_ready  = (state_q == ST_RUN) && !tx_busy;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// fields of the buffered frame
	assign f_type        = frame_q[2];
	assign f_addr        = {frame_q[3], frame_q[4]};
	assign f_data        = {frame_q[5], frame_q[6]};
	assign f_in_range    = {1'b0, f_addr} < DEPTH_L;
	assign host_in_range = {1'b0, host_addr} < DEPTH_L;
	assign crc_ok        = crc_q == {frame_q[7], last_byte_q};

	// type priority: send, then request, then query
	assign is_send  = f_type == code_send_q;
	assign is_req   = f_type == code_request_q;
	assign is_query = f_type == code_query_q;

	// store port control; a host write and a frame access never fall in the same or
	// adjacent cycles that matter, since a frame access only happens out of ST_EVAL
	// while input is held, so no forwarding is needed
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = 16'h0000;
		mem_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_RUN: begin
				if (in_fire && (mode == MODE_HOST_WR) && host_in_range) begin
					mem_we    = 1'b1;
					mem_waddr = host_addr[ADDR_W-1:0];
					mem_wdata = host_value;
				end
			end
			ST_EVAL: begin
				mem_re = 1'b1;
				if (crc_ok && is_send && f_in_range) begin
					mem_we    = 1'b1;
					mem_waddr = f_addr[ADDR_W-1:0];
					mem_wdata = f_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[f_addr[ADDR_W-1:0]];
		end
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_idx_q       <= '0;
			step_q          <= 4'd0;
			busy_q          <= 1'b0;
			chk_idx_q       <= 3'd0;
			crc_poly_q      <= 16'h1021;
			code_send_q     <= 8'd1;
			code_request_q  <= 8'd2;
			code_query_q    <= 8'd3;
			code_response_q <= 8'd4;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + ADDR_W'(1);
					if (clr_idx_q == CLR_LAST) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (in_fire) begin
						case (mode)
							MODE_CLEAR: begin
								busy_q <= 1'b0;
							end
							MODE_RX: begin
								if (busy_q) begin
									// receiver parked until the host clears it
									step_q <= 4'd0;
								end else begin
									case (step_q)
										4'd0: begin
											if (rx_byte == SYNC_FIRST) begin
												step_q <= 4'd1;
											end
										end
										4'd1: begin
											// lost sync goes back to the hunt without a recheck
											step_q <= (rx_byte == SYNC_SECOND) ? 4'd2 : 4'd0;
										end
										STEP_LAST: begin
											step_q    <= 4'd0;
											chk_idx_q <= 3'd0;
											state_q   <= ST_CHECK;
										end
										default: begin
											step_q <= step_q + 4'd1;
										end
									endcase
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHECK: begin
					chk_idx_q <= chk_idx_q + 3'd1;
					if (chk_idx_q == CHECK_LAST) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (crc_ok) begin
						busy_q <= 1'b1;
					end
					state_q <= ST_JOB;
				end
				ST_JOB: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase

			if (cfg_valid) begin
				case (cfg_index)
					CFG_POLY:     crc_poly_q      <= cfg_data;
					CFG_SEND:     code_send_q     <= cfg_data[7:0];
					CFG_REQUEST:  code_request_q  <= cfg_data[7:0];
					CFG_QUERY:    code_query_q    <= cfg_data[7:0];
					CFG_RESPONSE: code_response_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// frame buffer, crc check and job payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RUN: begin
				if (in_fire && (mode == MODE_RX) && !busy_q) begin
					if (step_q == STEP_LAST) begin
						last_byte_q <= rx_byte;
						crc_q       <= 16'h0000;
					end else begin
						frame_q[step_q[2:0]] <= rx_byte;
					end
				end
			end
			ST_CHECK: begin
				crc_q <= crc_byte(crc_q, frame_q[chk_idx_q], crc_poly_q);
			end
			ST_EVAL: begin
				job_q.addr    <= f_addr;
				job_q.data    <= f_data;
				job_q.code    <= 8'h00;
				job_q.persist <= 1'b0;
				rd_sel_q      <= 1'b0;
				oob_q         <= !f_in_range;
				if (!crc_ok) begin
					job_q.kind <= KIND_CRC_ERR;
				end else if (is_send) begin
					job_q.kind    <= KIND_REPLY;
					job_q.code    <= code_response_q;
					job_q.persist <= 1'b1;
				end else if (is_req) begin
					job_q.kind <= KIND_REPLY;
					job_q.code <= code_send_q;
					rd_sel_q   <= 1'b1;
				end else if (is_query) begin
					job_q.kind <= KIND_QUERY;
				end else begin
					job_q.kind <= KIND_ACCEPT;
				end
			end
			default: begin
			end
		endcase
	end

	// read data lands here; out-of-range reads give zero
	always_comb begin
		tx_job = job_q;
		if (rd_sel_q) begin
			tx_job.data = oob_q ? 16'h0000 : rd_data_q;
		end
	end

	crcfl_tx u_tx (
		.clk             (clk),
		.arst_n          (arst_n),
		.crc_poly        (crc_poly_q),
		.job_valid       (state_q == ST_JOB),
		.job             (tx_job),
		.busy            (tx_busy),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.tx_byte         (tx_byte),
		.last            (last),
		.reg_addr        (reg_addr),
		.persist_request (persist_request)
	);

endmodule

// ----- hdl/crcfl_checker.sv -----
`include "crc_framed_register_link_slave_defines.svh"

module crcfl_checker import crcfl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  tx_byte,
	input logic        last,
	input logic [15:0] reg_addr,
	input logic        persist_request
);

	`CRCFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`CRCFL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(kind) && $stable(tx_byte) && $stable(last) && $stable(reg_addr) && $stable(persist_request), "stalled result changed")
	`CRCFL_ASSERT_NOW(a_status_single, out_valid && (kind != KIND_REPLY), (tx_byte == 8'h00) && last && !persist_request, "status result not a lone zero item")
	`CRCFL_ASSERT_NOW(a_persist_last, out_valid && persist_request, last && (kind == KIND_REPLY), "persist request off the closing reply byte")

endmodule

bind crc_framed_register_link_slave crcfl_checker u_crcfl_checker (.*);
